// File: rtl/bfsp_pkg.sv
// Shared constants, types and codes for the Bellman-Ford shortest path engine.
package bfsp_pkg;

  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 4096;

  localparam int NODE_W    = 10;                      // node index field width
  localparam int NODE_AW   = $clog2(MAX_NODES);       // distance memory address
  localparam int EDGE_AW   = $clog2(MAX_EDGES);       // edge memory address
  localparam int CNT_W     = $clog2(MAX_EDGES + 1);   // loaded edge count
  localparam int PASS_W    = 11;                      // node_count register width
  localparam int DIST_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 11;

  localparam logic signed [DIST_W-1:0] DIST_SENTINEL = 32'sh0A0A0A0A;
  localparam logic signed [DIST_W-1:0] DIST_MAX      = 32'sh7FFFFFFF;
  localparam logic signed [DIST_W-1:0] DIST_MIN      = 32'sh80000000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_NODE = 1'b1;

  // Input mode and result kind codes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_REPLY  = 1'b1;

  // One stored edge
  typedef struct packed {
    logic [NODE_W-1:0]        tail;
    logic [NODE_W-1:0]        head;
    logic signed [DIST_W-1:0] cost;
  } edge_t;

  // Relaxation unit result
  typedef struct packed {
    logic                     better;
    logic signed [DIST_W-1:0] cand;
  } relax_res_t;

endpackage

// File: rtl/bfsp_if.sv
// Valid/ready channel interfaces for the command and response words.
interface bfsp_in_if;
  import bfsp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [NODE_W-1:0]        from_node;
  logic [NODE_W-1:0]        to_node;
  logic signed [DIST_W-1:0] weight;
  logic                     last_edge;

  modport source (output valid, mode, from_node, to_node, weight, last_edge,
                  input ready);
  modport sink   (input valid, mode, from_node, to_node, weight, last_edge,
                  output ready);
endinterface

interface bfsp_out_if;
  import bfsp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic                     negative_cycle;
  logic                     edge_overflow;
  logic signed [DIST_W-1:0] distance;

  modport source (output valid, kind, negative_cycle, edge_overflow, distance,
                  input ready);
  modport sink   (input valid, kind, negative_cycle, edge_overflow, distance,
                  output ready);
endinterface

// File: rtl/bfsp_edge_store.sv
// Edge memory: one write port for loads, one registered read port for the solve.
module bfsp_edge_store (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [bfsp_pkg::EDGE_AW-1:0]   wr_addr,
  input  bfsp_pkg::edge_t                wr_data,
  input  logic                           rd_en,
  input  logic [bfsp_pkg::EDGE_AW-1:0]   rd_addr,
  output bfsp_pkg::edge_t                rd_data
);
  import bfsp_pkg::*;

  edge_t mem [MAX_EDGES];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/bfsp_dist_store.sv
// Node distance memory: two registered read ports and one write port.
module bfsp_dist_store (
  input  logic                                  clk,
  input  logic [bfsp_pkg::NODE_AW-1:0]          rd_addr_a,
  output logic signed [bfsp_pkg::DIST_W-1:0]    rd_data_a,
  input  logic [bfsp_pkg::NODE_AW-1:0]          rd_addr_b,
  output logic signed [bfsp_pkg::DIST_W-1:0]    rd_data_b,
  input  logic                                  wr_en,
  input  logic [bfsp_pkg::NODE_AW-1:0]          wr_addr,
  input  logic signed [bfsp_pkg::DIST_W-1:0]    wr_data
);
  import bfsp_pkg::*;

  logic signed [DIST_W-1:0] mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// File: rtl/bfsp_relax_unit.sv
// Shared relaxation unit: saturating tail distance plus cost, compared to head.
module bfsp_relax_unit (
  input  logic signed [bfsp_pkg::DIST_W-1:0] tail_dist,
  input  logic signed [bfsp_pkg::DIST_W-1:0] head_dist,
  input  logic signed [bfsp_pkg::DIST_W-1:0] cost,
  output bfsp_pkg::relax_res_t               res
);
  import bfsp_pkg::*;

  logic signed [DIST_W:0]   sum;
  logic signed [DIST_W-1:0] cand;

  // One guard bit catches overflow; clamp to the signed limits
  assign sum = {tail_dist[DIST_W-1], tail_dist} + {cost[DIST_W-1], cost};

  always_comb begin
    if (sum[DIST_W] != sum[DIST_W-1]) begin
      cand = sum[DIST_W] ? DIST_MIN : DIST_MAX;
    end else begin
      cand = sum[DIST_W-1:0];
    end
  end

  assign res.cand   = cand;
  assign res.better = head_dist > cand;

endmodule

// File: rtl/bellman_ford_shortest_path.sv
// Bellman-Ford engine: edge loads write the edge memory on acceptance; a query's distance read
// and reply word are registered in turn. A solve clears the 1024-entry distance memory, then
// relaxes each edge (edge read, distance read, add/compare/write) on one shared unit, for at
// most node_count passes. Reset (synchronous, active high) clears control state and starts a
// sweep over all 1024 entries that sets every distance to the sentinel; no word is accepted
// meanwhile.
module bellman_ford_shortest_path (
  input  logic                              clk,
  input  logic                              rst,
  bfsp_in_if.sink                           cmd,
  bfsp_out_if.source                        rsp,
  input  logic                              cfg_wr_en,
  input  logic [bfsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfsp_pkg::CFG_W-1:0]        cfg_data
);
  import bfsp_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR   = 6'b000001,
    S_IDLE    = 6'b000010,
    S_QUERY   = 6'b000100,
    S_EDGE_RD = 6'b001000,
    S_DIST_RD = 6'b010000,
    S_RELAX   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic [PASS_W-1:0]  node_count;
  logic [NODE_W-1:0]  source_node;
  logic [CNT_W-1:0]   edge_count;
  logic               overflow;
  logic [NODE_AW-1:0] clr_addr;
  logic               clr_for_solve;
  logic [EDGE_AW-1:0] edge_idx;
  logic [PASS_W-1:0]  pass_cnt;
  logic               changed;

  logic                     out_valid;
  logic                     out_kind;
  logic                     out_neg;
  logic                     out_ovf;
  logic signed [DIST_W-1:0] out_dist;

  logic                     cmd_fire;
  logic                     edge_full;
  logic                     edge_wr;
  edge_t                    edge_wdata;
  edge_t                    edge_rdata;
  logic [NODE_AW-1:0]       dist_addr_a;
  logic signed [DIST_W-1:0] dist_a;
  logic signed [DIST_W-1:0] dist_b;
  logic                     dist_wr;
  logic [NODE_AW-1:0]       dist_waddr;
  logic signed [DIST_W-1:0] dist_wdata;
  relax_res_t               relax;
  logic                     last_in_pass;
  logic                     pass_changed;
  logic                     clr_last;

  assign cmd.ready = (state == S_IDLE) && !out_valid;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign edge_full = edge_count >= CNT_W'(MAX_EDGES);

  assign rsp.valid          = out_valid;
  assign rsp.kind           = out_kind;
  assign rsp.negative_cycle = out_neg;
  assign rsp.edge_overflow  = out_ovf;
  assign rsp.distance       = out_dist;

  // Edge store
  assign edge_wr         = cmd_fire && (cmd.mode == MODE_LOAD) && !edge_full;
  assign edge_wdata.tail = cmd.from_node;
  assign edge_wdata.head = cmd.to_node;
  assign edge_wdata.cost = cmd.weight;

  bfsp_edge_store u_edges (
    .clk     (clk),
    .wr_en   (edge_wr),
    .wr_addr (edge_count[EDGE_AW-1:0]),
    .wr_data (edge_wdata),
    .rd_en   (state == S_EDGE_RD),
    .rd_addr (edge_idx),
    .rd_data (edge_rdata)
  );

  // Distance store: port A serves queries and the edge tail, port B the head
  assign dist_addr_a = (state == S_DIST_RD) ? edge_rdata.tail : cmd.from_node;
  assign clr_last    = clr_addr == NODE_AW'(MAX_NODES - 1);

  always_comb begin
    dist_wr    = 1'b0;
    dist_waddr = clr_addr;
    dist_wdata = DIST_SENTINEL;
    case (state)
      S_CLEAR: begin
        dist_wr = 1'b1;
        if (clr_for_solve && (clr_addr == source_node)) begin
          dist_wdata = '0;
        end
      end
      S_RELAX: begin
        dist_wr    = relax.better;
        dist_waddr = edge_rdata.head;
        dist_wdata = relax.cand;
      end
      default: ;
    endcase
  end

  bfsp_dist_store u_dist (
    .clk       (clk),
    .rd_addr_a (dist_addr_a),
    .rd_data_a (dist_a),
    .rd_addr_b (edge_rdata.head),
    .rd_data_b (dist_b),
    .wr_en     (dist_wr),
    .wr_addr   (dist_waddr),
    .wr_data   (dist_wdata)
  );

  bfsp_relax_unit u_relax (
    .tail_dist (dist_a),
    .head_dist (dist_b),
    .cost      (edge_rdata.cost),
    .res       (relax)
  );

  // Pass bookkeeping
  assign last_in_pass = (CNT_W'(edge_idx) + CNT_W'(1)) == edge_count;
  assign pass_changed = changed || relax.better;

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_last) begin
          if (clr_for_solve && (node_count != '0) && (edge_count != '0)) begin
            state_next = S_EDGE_RD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (cmd_fire) begin
          if (cmd.mode == MODE_QUERY) begin
            state_next = S_QUERY;
          end else if (cmd.last_edge) begin
            state_next = S_CLEAR;
          end
        end
      end
      S_QUERY:   state_next = S_IDLE;
      S_EDGE_RD: state_next = S_DIST_RD;
      S_DIST_RD: state_next = S_RELAX;
      S_RELAX: begin
        if (last_in_pass &&
            (!pass_changed || ((pass_cnt + PASS_W'(1)) == node_count))) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_EDGE_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= PASS_W'(1);
      source_node <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NODE_COUNT:  node_count  <= cfg_data[PASS_W-1:0];
        REG_SOURCE_NODE: source_node <= cfg_data[NODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Load, clear and solve control
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count    <= '0;
      overflow      <= 1'b0;
      clr_addr      <= '0;
      clr_for_solve <= 1'b0;
      edge_idx      <= '0;
      pass_cnt      <= '0;
      changed       <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + NODE_AW'(1);
          edge_idx <= '0;
          pass_cnt <= '0;
          changed  <= 1'b0;
          // empty graph or no passes ends the load here
          if (clr_last && clr_for_solve &&
              ((node_count == '0) || (edge_count == '0))) begin
            edge_count <= '0;
            overflow   <= 1'b0;
          end
        end
        S_IDLE: begin
          if (cmd_fire && (cmd.mode == MODE_LOAD)) begin
            if (edge_full) begin
              overflow <= 1'b1;
            end else begin
              edge_count <= edge_count + CNT_W'(1);
            end
            if (cmd.last_edge) begin
              clr_addr      <= '0;
              clr_for_solve <= 1'b1;
            end
          end
        end
        S_RELAX: begin
          if (last_in_pass) begin
            edge_idx <= '0;
            pass_cnt <= pass_cnt + PASS_W'(1);
            changed  <= 1'b0;
            if (state_next == S_IDLE) begin
              edge_count <= '0;
              overflow   <= 1'b0;
            end
          end else begin
            edge_idx <= edge_idx + EDGE_AW'(1);
            changed  <= pass_changed;
          end
        end
        default: ;
      endcase
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_QUERY) begin
      out_valid <= 1'b1;
    end else if (state == S_CLEAR && clr_last && clr_for_solve &&
                 ((node_count == '0) || (edge_count == '0))) begin
      out_valid <= 1'b1;
    end else if (state == S_RELAX && state_next == S_IDLE) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_QUERY: begin
        out_kind <= KIND_REPLY;
        out_neg  <= 1'b0;
        out_ovf  <= 1'b0;
        out_dist <= dist_a;
      end
      S_CLEAR: begin
        out_kind <= KIND_STATUS;
        out_neg  <= 1'b0;
        out_ovf  <= overflow;
        out_dist <= '0;
      end
      S_RELAX: begin
        out_kind <= KIND_STATUS;
        out_neg  <= pass_changed;
        out_ovf  <= overflow;
        out_dist <= '0;
      end
      default: ;
    endcase
  end

endmodule

// File: bench/bfsp_checker.sv
// Shortest path engine checker: predicts every response word and compares it.
module bfsp_checker (
  input  logic                           clk,
  input  logic                           rst,
  bfsp_in_if                             cmd,
  bfsp_out_if                            rsp,
  input  logic                           cfg_wr_en,
  input  logic [bfsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfsp_pkg::CFG_W-1:0]     cfg_data,
  output int                             fail_count,
  output int                             outstanding
);
  import bfsp_pkg::*;

  typedef struct {
    logic                     kind;
    logic                     negative_cycle;
    logic                     edge_overflow;
    logic signed [DIST_W-1:0] distance;
  } rsp_word_t;

  // Shadow copy of the engine state
  logic [NODE_W-1:0]        tail_mem [MAX_EDGES];
  logic [NODE_W-1:0]        head_mem [MAX_EDGES];
  logic signed [DIST_W-1:0] cost_mem [MAX_EDGES];
  logic signed [DIST_W-1:0] dist_mem [MAX_NODES];
  int unsigned              edge_count;
  bit                       edges_dropped;
  logic [PASS_W-1:0]        pass_limit;
  logic [NODE_W-1:0]        root_node;

  rsp_word_t pending_words[$];

  // Tail distance plus weight, clamped to the 32-bit signed range
  function automatic logic signed [DIST_W-1:0] clamp_sum(logic signed [DIST_W-1:0] a,
                                                          logic signed [DIST_W-1:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > longint'(DIST_MAX)) return DIST_MAX;
    if (s < longint'(DIST_MIN)) return DIST_MIN;
    return s[DIST_W-1:0];
  endfunction

  // Full solve over the loaded edges; returns 1 if the last pass still improved
  function automatic bit solve_paths();
    int unsigned              pass;
    int unsigned              j;
    bit                       changed;
    logic signed [DIST_W-1:0] cand;
    changed = 1'b0;
    foreach (dist_mem[i]) dist_mem[i] = DIST_SENTINEL;
    dist_mem[root_node] = '0;
    for (pass = 0; pass < pass_limit; pass++) begin
      changed = 1'b0;
      for (j = 0; j < edge_count; j++) begin
        cand = clamp_sum(dist_mem[tail_mem[j]], cost_mem[j]);
        if (dist_mem[head_mem[j]] > cand) begin
          dist_mem[head_mem[j]] = cand;
          changed = 1'b1;
        end
      end
      if (!changed) break;
    end
    return changed;
  endfunction

  always @(posedge clk) begin : monitor
    rsp_word_t want;
    if (rst) begin
      foreach (dist_mem[i]) dist_mem[i] = DIST_SENTINEL;
      edge_count    = 0;
      edges_dropped = 1'b0;
      pass_limit    = PASS_W'(1);
      root_node     = '0;
      pending_words.delete();
      fail_count    = 0;
    end else begin
      // register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_NODE_COUNT:  pass_limit = cfg_data[PASS_W-1:0];
          REG_SOURCE_NODE: root_node  = cfg_data[NODE_W-1:0];
          default: ;
        endcase
      end

      // accepted command word
      if (cmd.valid && cmd.ready) begin
        if (cmd.mode == MODE_QUERY) begin
          want.kind           = KIND_REPLY;
          want.negative_cycle = 1'b0;
          want.edge_overflow  = 1'b0;
          want.distance       = dist_mem[cmd.from_node];
          pending_words.push_back(want);
        end else begin
          if (edge_count < MAX_EDGES) begin
            tail_mem[edge_count] = cmd.from_node;
            head_mem[edge_count] = cmd.to_node;
            cost_mem[edge_count] = cmd.weight;
            edge_count++;
          end else begin
            edges_dropped = 1'b1;
          end
          if (cmd.last_edge) begin
            want.kind           = KIND_STATUS;
            want.negative_cycle = solve_paths();
            want.edge_overflow  = edges_dropped;
            want.distance       = '0;
            pending_words.push_back(want);
            edge_count    = 0;
            edges_dropped = 1'b0;
          end
        end
      end

      // accepted response word
      if (rsp.valid && rsp.ready) begin
        if (pending_words.size() == 0) begin
          $error("response word with nothing expected");
          fail_count++;
        end else begin
          want = pending_words.pop_front();
          if (rsp.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, rsp.kind);
            fail_count++;
          end
          if (rsp.negative_cycle !== want.negative_cycle) begin
            $error("negative_cycle: expected %0d, got %0d",
                   want.negative_cycle, rsp.negative_cycle);
            fail_count++;
          end
          if (rsp.edge_overflow !== want.edge_overflow) begin
            $error("edge_overflow: expected %0d, got %0d",
                   want.edge_overflow, rsp.edge_overflow);
            fail_count++;
          end
          if (rsp.distance !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, rsp.distance);
            fail_count++;
          end
        end
      end
    end
    outstanding <= pending_words.size();
  end

endmodule

// File: bench/tb_bellman_ford_shortest_path.sv
// Testbench top for the shortest path engine: stimulus, idling and verdict.
module tb_bellman_ford_shortest_path;
  import bfsp_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   fail_count;
  int                   outstanding;
  int                   idle_pct;
  int                   stall_pct;

  bfsp_in_if  cmd ();
  bfsp_out_if rsp ();

  always #6 clk = ~clk;

  bellman_ford_shortest_path uut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rsp       (rsp),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bfsp_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Receiver back-pressure
  always @(posedge clk) begin
    rsp.ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  // Hard stop in case the engine hangs
  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic signed [DIST_W-1:0] random_weight();
    int v;
    v = $urandom_range(20);
    case ($urandom_range(9))
      0:       return DIST_MAX;
      1:       return DIST_MIN;
      2, 3:    return $urandom;
      4, 5:    return -v;
      default: return $urandom_range(100);
    endcase
  endfunction

  // Mostly nodes near the window base so that paths actually form
  function automatic logic [NODE_W-1:0] pick_node(int base);
    if ($urandom_range(99) < 85) return NODE_W'(base + $urandom_range(7));
    return NODE_W'($urandom_range(MAX_NODES - 1));
  endfunction

  // One command word; returns right after the edge that accepted it
  task automatic send_word(input logic m, input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b,
                           input logic signed [DIST_W-1:0] w, input logic lst);
    while ($urandom_range(99) < idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid     <= 1'b1;
    cmd.mode      <= m;
    cmd.from_node <= a;
    cmd.to_node   <= b;
    cmd.weight    <= w;
    cmd.last_edge <= lst;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  task automatic load_edge(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b,
                           input logic signed [DIST_W-1:0] w, input logic lst);
    send_word(MODE_LOAD, a, b, w, lst);
  endtask

  // Query with random don't-care fields
  task automatic query_node(input logic [NODE_W-1:0] n);
    send_word(MODE_QUERY, n, NODE_W'($urandom_range(MAX_NODES - 1)), $urandom,
              1'($urandom_range(1)));
  endtask

  // Hold off until every expected word is back, then let the engine settle
  task automatic drain();
    cmd.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [PASS_W-1:0] nc, input logic [NODE_W-1:0] src);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_NODE_COUNT;
    cfg_data  <= CFG_W'(nc);
    @(posedge clk);
    cfg_index <= REG_SOURCE_NODE;
    cfg_data  <= CFG_W'(src);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    int          im;
    int          k;
    int          base;
    int          sent;
    int          n_edges;
    int          n_q;
    int          e_idx;
    int          maxe;
    logic [PASS_W-1:0] nc;

    rst           = 1'b1;
    cmd.valid     = 1'b0;
    cmd.mode      = MODE_LOAD;
    cmd.from_node = '0;
    cmd.to_node   = '0;
    cmd.weight    = '0;
    cmd.last_edge = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = REG_NODE_COUNT;
    cfg_data      = '0;
    idle_pct      = 0;
    stall_pct     = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: reset distances, saturation, unreached relaxing, negative cycle
    set_config(4, 0);
    query_node(0);
    query_node(MAX_NODES - 1);
    load_edge(0, 1, 5, 1'b0);
    load_edge(1, 2, -3, 1'b0);
    load_edge(2, 3, DIST_MAX, 1'b0);
    load_edge(3, 4, DIST_MAX, 1'b0);
    load_edge(0, 5, DIST_MIN, 1'b0);
    load_edge(5, 6, -1, 1'b0);
    load_edge(1023, 600, -1, 1'b0);
    load_edge(600, 1023, 0, 1'b1);
    query_node(1);
    query_node(3);
    query_node(4);
    query_node(6);
    query_node(600);
    query_node(1023);
    drain();

    // pass count equal to MAX_NODES with a cycle that never settles
    set_config(1024, 1023);
    load_edge(1023, 7, -1, 1'b0);
    load_edge(7, 1023, -1, 1'b1);
    query_node(7);
    drain();

    // zero passes: only the source leaves the sentinel
    set_config(0, 512);
    load_edge(512, 3, -5, 1'b1);
    query_node(512);
    query_node(3);
    drain();

    // random phases over idling modes and pass counts
    for (im = 0; im < 4; im++) begin
      case (im)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 60; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      for (k = 0; k < 5; k++) begin
        base = ($urandom_range(4) == 0) ? MAX_NODES - 8 : $urandom_range(MAX_NODES - 8);
        case (k)
          0:       nc = 0;
          1:       nc = 1;
          2:       nc = PASS_W'($urandom_range(2, 8));
          3:       nc = PASS_W'($urandom_range(9, 40));
          default: nc = 1024;
        endcase
        maxe = (k == 4) ? 3 : 8;
        set_config(nc, NODE_W'(base + $urandom_range(7)));
        sent = 0;
        while (sent < 25) begin
          n_edges = $urandom_range(1, maxe);
          for (e_idx = 0; e_idx < n_edges; e_idx++) begin
            // occasional query in the middle of a load
            if ($urandom_range(9) == 0) begin
              query_node(pick_node(base));
              sent++;
            end
            load_edge(pick_node(base), pick_node(base), random_weight(), e_idx == n_edges - 1);
            sent++;
          end
          n_q = $urandom_range(3);
          for (e_idx = 0; e_idx < n_q; e_idx++) begin
            query_node(pick_node(base));
            sent++;
          end
        end
        drain();
      end
    end

    // edge memory overflow: one more edge than it holds, then a clean load
    idle_pct  = 0;
    stall_pct = 0;
    set_config(1, NODE_W'($urandom_range(MAX_NODES - 1)));
    for (e_idx = 0; e_idx <= MAX_EDGES; e_idx++) begin
      load_edge(NODE_W'($urandom_range(MAX_NODES - 1)), NODE_W'($urandom_range(MAX_NODES - 1)),
                random_weight(), e_idx == MAX_EDGES);
    end
    query_node(NODE_W'($urandom_range(MAX_NODES - 1)));
    load_edge(0, 1, 1, 1'b0);
    load_edge(1, 2, 1, 1'b1);
    query_node(2);
    drain();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
